### hdl/mip_chain_offset_calc_core_assert.svh
// Assertion macros shared by the offset calculator RTL.
// Both macros sample on clk and are disabled while arst_n is low.
`ifndef MIP_CHAIN_OFFSET_CALC_CORE_ASSERT_SVH
`define MIP_CHAIN_OFFSET_CALC_CORE_ASSERT_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLIES(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");
`define ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");
`else
`define ASSERT_IMPLIES(label, ante, cons)
`define ASSERT_NEXT(label, ante, cons)
`endif
`endif

### hdl/mipoff_pkg.sv
package mipoff_pkg;

	typedef logic [63:0] offset_t;
	typedef logic [22:0] recip_t;

	// Register indexes of the configuration port
	localparam logic [2:0] CFG_BYTES_PER_BLOCK  = 3'd0;
	localparam logic [2:0] CFG_BLOCK_WIDTH      = 3'd1;
	localparam logic [2:0] CFG_BLOCK_HEIGHT     = 3'd2;
	localparam logic [2:0] CFG_SAMPLE_MODE      = 3'd3;
	localparam logic [2:0] CFG_DIMS_IN_LAYER    = 3'd4;
	localparam logic [2:0] CFG_TILE_HEIGHT_LOG  = 3'd5;
	localparam logic [2:0] CFG_TILE_DEPTH_LOG   = 3'd6;
	localparam logic [2:0] CFG_SPARSE_ALIGN_LOG = 3'd7;

	// Reciprocal scale: quotient = (n * recip) >> RECIP_SHIFT, exact for n < 2^18
	localparam int RECIP_SHIFT = 22;

	// Base gob is 512 bytes
	localparam logic [4:0] GOB_BYTES_LOG = 5'd9;

	// ceil(2^22 / d) for block sizes; zero acts as one
	function automatic recip_t recip_of(input logic [3:0] d);
		recip_t r;
		case (d)
			4'd2:    r = 23'd2097152;
			4'd3:    r = 23'd1398102;
			4'd4:    r = 23'd1048576;
			4'd5:    r = 23'd838861;
			4'd6:    r = 23'd699051;
			4'd7:    r = 23'd599187;
			4'd8:    r = 23'd524288;
			4'd9:    r = 23'd466034;
			4'd10:   r = 23'd419431;
			4'd11:   r = 23'd381301;
			4'd12:   r = 23'd349526;
			4'd13:   r = 23'd322639;
			4'd14:   r = 23'd299594;
			4'd15:   r = 23'd279621;
			default: r = 23'd4194304;
		endcase
		return r;
	endfunction

	// Sparse tile width in blocks: 64 / bytes_per_block, zero acts as one
	function automatic logic [6:0] sparse_tw_of(input logic [4:0] bpb);
		logic [6:0] r;
		case (bpb)
			5'd0, 5'd1:                             r = 7'd64;
			5'd2:                                   r = 7'd32;
			5'd3:                                   r = 7'd21;
			5'd4:                                   r = 7'd16;
			5'd5:                                   r = 7'd12;
			5'd6:                                   r = 7'd10;
			5'd7:                                   r = 7'd9;
			5'd8:                                   r = 7'd8;
			5'd9:                                   r = 7'd7;
			5'd10:                                  r = 7'd6;
			5'd11, 5'd12:                           r = 7'd5;
			5'd13, 5'd14, 5'd15, 5'd16:             r = 7'd4;
			5'd17, 5'd18, 5'd19, 5'd20, 5'd21:      r = 7'd3;
			default:                                r = 7'd2;
		endcase
		return r;
	endfunction

	// Floor log2 of bytes per block, zero acts as one
	function automatic logic [2:0] bpb_log_of(input logic [4:0] bpb);
		logic [2:0] r;
		if (bpb[4])      r = 3'd4;
		else if (bpb[3]) r = 3'd3;
		else if (bpb[2]) r = 3'd2;
		else if (bpb[1]) r = 3'd1;
		else             r = 3'd0;
		return r;
	endfunction

	// Shrink a tile shift: largest s <= shift with s == 0 or (unit << (s-1)) < dim
	function automatic logic [2:0] fit_shift(input logic [2:0] shift, input logic gob_unit,
			input logic [16:0] dim);
		logic [16:0] thr;
		logic [2:0]  r;
		r = 3'd0;
		for (int s = 1; s < 8; s++) begin
			thr = (gob_unit ? 17'd8 : 17'd1) << (s - 1);
			if ((3'(s) <= shift) && (thr < dim)) r = 3'(s);
		end
		return r;
	endfunction

endpackage

### hdl/mip_chain_offset_calc_core.sv
// Mip chain offset calculator for block-linear tiled images.
// Input channel (in_valid / in_stall) carries one query: base width, height,
// depth and a level number. Output channel (out_valid / out_stall) returns
// byte_offset, the sum of the tiled sizes of all levels below that level.
// Configuration (cfg_we / cfg_index / cfg_data) sets the format and tiling
// registers; write it only while no query is in flight.
// One shared 30x23 multiplier under a small sequencer walks the levels. Each
// level runs through two reciprocal divisions, tile fit, tile counts, two
// products and a shift-accumulate; min(level_index, MAX_LEVELS) levels are
// walked per query. in_stall stays high while a query is worked on, so a new
// query is taken only once the sequencer is back in idle.
// The result sits in an output register, so the next query is accepted while
// it waits; a stalled receiver only holds the sequencer at its final step if
// a second result is ready before the first beat has been taken.
// Reset returns the registers to their defaults (4,1,1,0,2,0,0,0), empties
// the output register and idles the sequencer.
`include "mip_chain_offset_calc_core_assert.svh"
module mip_chain_offset_calc_core
	import mipoff_pkg::*;
#(
	parameter int MAX_LEVELS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [4:0]  cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [14:0] image_width,
	input  logic [14:0] image_height,
	input  logic [11:0] image_depth,
	input  logic [4:0]  level_index,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [63:0] byte_offset
);

	localparam int LVL_W = $clog2(MAX_LEVELS + 1);
	localparam logic [4:0] MAX_LVL_IN = 5'(MAX_LEVELS);

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_DIVW  = 4'd1;
	localparam logic [3:0] ST_DIVH  = 4'd2;
	localparam logic [3:0] ST_FIT   = 4'd3;
	localparam logic [3:0] ST_TILES = 4'd4;
	localparam logic [3:0] ST_MWH   = 4'd5;
	localparam logic [3:0] ST_MWHD  = 4'd6;
	localparam logic [3:0] ST_ACC   = 4'd7;
	localparam logic [3:0] ST_DONE  = 4'd8;

	// Configuration registers
	logic [4:0] bpb_q;
	logic [3:0] bw_q;
	logic [3:0] bh_q;
	logic [1:0] smode_q;
	logic [1:0] dims_q;
	logic [2:0] thl_q;
	logic [2:0] tdl_q;
	logic [2:0] sal_q;

	// Sequencer and datapath registers
	logic [3:0]       state_q;
	logic [LVL_W-1:0] lvl_left_q;
	logic             out_valid_q;
	offset_t          byte_offset_q;
	offset_t          offset_q;
	logic [16:0]      mw_q;
	logic [15:0]      mh_q;
	logic [11:0]      md_q;
	logic [16:0]      lw_q;
	logic [16:0]      lh_q;
	logic [11:0]      ld_q;
	logic [2:0]       hs_q;
	logic [2:0]       ds_q;
	logic [15:0]      wt_q;
	logic [15:0]      ht_q;
	logic [12:0]      dt_q;
	logic [52:0]      prod_q;

	logic             in_acc;
	logic             out_free;
	logic [1:0]       sx_log;
	logic [1:0]       sy_log;
	logic [3:0]       bw_eff;
	logic [3:0]       bh_eff;
	logic [LVL_W-1:0] lvl_start;

	logic [29:0] mul_a;
	logic [22:0] mul_b;
	logic [52:0] mul_p;
	logic        mul_en;

	logic [17:0] nw;
	logic [17:0] nh;
	logic [16:0] lh_next;
	logic [11:0] ld_next;

	logic [20:0] lw_bytes;
	logic [21:0] wt_sum0;
	logic [15:0] wt0;
	logic [7:0]  apow;
	logic [16:0] amask;
	logic [16:0] wt_sum1;
	logic [16:0] wt_al;
	logic        sparse_on;
	logic [17:0] hg_sum;
	logic [14:0] h_gobs;
	logic [7:0]  hpow;
	logic [16:0] ht_sum;
	logic [7:0]  dpow;
	logic [13:0] dt_sum;
	logic [4:0]  acc_sh;

	assign in_acc    = in_valid && !in_stall;
	assign in_stall  = (state_q != ST_IDLE);
	assign out_free  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;
	assign byte_offset = byte_offset_q;

	// Sample-count shifts and block sizes with zero taken as one
	always_comb begin
		case (smode_q)
			2'd1:    begin sx_log = 2'd1; sy_log = 2'd0; end
			2'd2:    begin sx_log = 2'd1; sy_log = 2'd1; end
			2'd3:    begin sx_log = 2'd2; sy_log = 2'd1; end
			default: begin sx_log = 2'd0; sy_log = 2'd0; end
		endcase
	end
	assign bw_eff = (bw_q == 4'd0) ? 4'd1 : bw_q;
	assign bh_eff = (bh_q == 4'd0) ? 4'd1 : bh_q;
	assign lvl_start = (level_index > MAX_LVL_IN) ? LVL_W'(MAX_LEVELS) : LVL_W'(level_index);

	// Round-up numerators of the current level
	assign nw = {1'b0, ((mw_q == 17'd0) ? 17'd1 : mw_q)} + 18'(bw_eff) - 18'd1;
	assign nh = {2'b0, ((mh_q == 16'd0) ? 16'd1 : mh_q)} + 18'(bh_eff) - 18'd1;

	// Level height and depth from the height quotient and the depth register
	assign lh_next = (dims_q >= 2'd2) ? prod_q[RECIP_SHIFT+16:RECIP_SHIFT] : 17'd1;
	assign ld_next = (dims_q == 2'd3) ? ((md_q == 12'd0) ? 12'd1 : md_q) : 12'd1;

	// Tile counts of the current level
	assign lw_bytes  = {4'b0, lw_q} << bpb_log_of(bpb_q);
	assign wt_sum0   = {1'b0, lw_bytes} + 22'd63;
	assign wt0       = wt_sum0[21:6];
	assign apow      = 8'd1 << sal_q;
	assign amask     = {9'b0, apow} - 17'd1;
	assign wt_sum1   = {1'b0, wt0} + amask;
	assign wt_al     = wt_sum1 & ~amask;
	assign sparse_on = (sal_q != 3'd0)
		&& ({10'b0, sparse_tw_of(bpb_q)} <= lw_q)
		&& ((17'd8 << thl_q) <= lh_q)
		&& ((12'd1 << tdl_q) <= ld_q);
	assign hg_sum    = {1'b0, lh_q} + 18'd7;
	assign h_gobs    = hg_sum[17:3];
	assign hpow      = 8'd1 << hs_q;
	assign ht_sum    = {2'b0, h_gobs} + {9'b0, hpow} - 17'd1;
	assign dpow      = 8'd1 << ds_q;
	assign dt_sum    = {2'b0, ld_q} + {6'b0, dpow} - 14'd1;
	assign acc_sh    = GOB_BYTES_LOG + 5'(hs_q) + 5'(ds_q);

	// Select operands of the shared multiplier
	always_comb begin
		mul_en = 1'b1;
		mul_a  = 30'd0;
		mul_b  = 23'd0;
		case (state_q)
			ST_DIVW: begin
				mul_a = 30'(nw);
				mul_b = recip_of(bw_q);
			end
			ST_DIVH: begin
				mul_a = 30'(nh);
				mul_b = recip_of(bh_q);
			end
			ST_MWH: begin
				mul_a = 30'(wt_q);
				mul_b = 23'(ht_q);
			end
			ST_MWHD: begin
				mul_a = prod_q[29:0];
				mul_b = 23'(dt_q);
			end
			default: mul_en = 1'b0;
		endcase
	end
	assign mul_p = {23'b0, mul_a} * {30'b0, mul_b};

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bpb_q   <= 5'd4;
			bw_q    <= 4'd1;
			bh_q    <= 4'd1;
			smode_q <= 2'd0;
			dims_q  <= 2'd2;
			thl_q   <= 3'd0;
			tdl_q   <= 3'd0;
			sal_q   <= 3'd0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_BYTES_PER_BLOCK:  bpb_q   <= cfg_data;
				CFG_BLOCK_WIDTH:      bw_q    <= cfg_data[3:0];
				CFG_BLOCK_HEIGHT:     bh_q    <= cfg_data[3:0];
				CFG_SAMPLE_MODE:      smode_q <= cfg_data[1:0];
				CFG_DIMS_IN_LAYER:    dims_q  <= cfg_data[1:0];
				CFG_TILE_HEIGHT_LOG:  thl_q   <= cfg_data[2:0];
				CFG_TILE_DEPTH_LOG:   tdl_q   <= cfg_data[2:0];
				CFG_SPARSE_ALIGN_LOG: sal_q   <= cfg_data[2:0];
				default: ;
			endcase
		end
	end

	// Advance the sequencer, count levels, hold the output beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			lvl_left_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						lvl_left_q <= lvl_start;
						state_q    <= (lvl_start == '0) ? ST_DONE : ST_DIVW;
					end
				end
				ST_DIVW:  state_q <= ST_DIVH;
				ST_DIVH:  state_q <= ST_FIT;
				ST_FIT:   state_q <= ST_TILES;
				ST_TILES: state_q <= ST_MWH;
				ST_MWH:   state_q <= ST_MWHD;
				ST_MWHD:  state_q <= ST_ACC;
				ST_ACC: begin
					lvl_left_q <= lvl_left_q - LVL_W'(1);
					state_q    <= (lvl_left_q == LVL_W'(1)) ? ST_DONE : ST_DIVW;
				end
				ST_DONE: begin
					if (out_free) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath: load the query, run level steps, accumulate, drop result
	always_ff @(posedge clk) begin
		if (mul_en) prod_q <= mul_p;
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					mw_q     <= {2'b0, image_width} << sx_log;
					mh_q     <= {1'b0, image_height} << sy_log;
					md_q     <= image_depth;
					offset_q <= '0;
				end
			end
			ST_DIVH: lw_q <= prod_q[RECIP_SHIFT+16:RECIP_SHIFT];
			ST_FIT: begin
				lh_q <= lh_next;
				ld_q <= ld_next;
				hs_q <= fit_shift(thl_q, 1'b1, lh_next);
				ds_q <= fit_shift(tdl_q, 1'b0, {5'b0, ld_next});
			end
			ST_TILES: begin
				wt_q <= sparse_on ? wt_al[15:0] : wt0;
				ht_q <= 16'(ht_sum >> hs_q);
				dt_q <= 13'(dt_sum >> ds_q);
			end
			ST_ACC: begin
				offset_q <= offset_q + ({11'b0, prod_q} << acc_sh);
				mw_q     <= mw_q >> 1;
				mh_q     <= mh_q >> 1;
				md_q     <= md_q >> 1;
			end
			ST_DONE: begin
				if (out_free) byte_offset_q <= offset_q;
			end
			default: ;
		endcase
	end

	// Checks
	`ASSERT_NEXT(a_accept_leaves_idle, in_valid && !in_stall, state_q != ST_IDLE)
	`ASSERT_IMPLIES(a_levels_left_when_busy, state_q != ST_IDLE && state_q != ST_DONE, lvl_left_q != '0)
	`ASSERT_NEXT(a_last_level_finishes, state_q == ST_ACC && lvl_left_q == LVL_W'(1), state_q == ST_DONE)
	`ASSERT_NEXT(a_done_loads_result, state_q == ST_DONE && !out_valid, out_valid && state_q == ST_IDLE)

endmodule
